@@ rtl/lru_page_replacement_core_defines.svh @@
// Assertion macros used by the checker file of the LRU page replacement core.
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define LRUPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LRUPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lrupr_pkg.sv @@
`default_nettype none

package lrupr_pkg;

   localparam int PAGE_PORT_BITS   = 16;
   localparam int FRAME_PORT_BITS  = 3;
   localparam int FAULT_BITS       = 16;
   localparam int CSR_BITS         = 4;

   typedef logic [PAGE_PORT_BITS-1:0]  page_port_type;
   typedef logic [FRAME_PORT_BITS-1:0] frame_port_type;
   typedef logic [FAULT_BITS-1:0]      fault_type;
   typedef logic [CSR_BITS-1:0]        csr_type;

   localparam fault_type FAULT_MAX       = '1;
   localparam csr_type   FRAMES_IN_USE_RESET = 4'd8;

endpackage

`default_nettype wire

@@ rtl/lru_page_replacement_core.sv @@
// LRU page replacement core. Each request transfer carries one page reference and produces
// exactly one response transfer with the hit flag, the frame now holding the page, the page
// evicted on a replacement (zero otherwise) and the saturating fault count. All frames are
// compared in parallel and the recency ranks are updated in the same cycle, so the core takes
// one reference per clock cycle; it stalls only while a finished response waits in the output
// register and is not taken. csr_write_data sets the number of frames, from frame 0 up, that
// take part in lookup and replacement (0 counts as 1, values above MAX_FRAMES saturate).
// Frames outside that range keep their pages and stay in the recency order. No clearing pass
// is needed after reset.
`default_nettype none

module lru_page_replacement_core #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [15:0]                req_page_number,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       rsp_hit,
   output logic [2:0]                 rsp_frame_index,
   output logic                       rsp_evicted_valid,
   output logic [15:0]                rsp_evicted_page,
   output logic [15:0]                rsp_fault_count,
   input  wire                        csr_write_enable,
   input  wire  [3:0]                 csr_write_data
);

   localparam int FW = $clog2(MAX_FRAMES);

   // Frame table.
   logic [PAGE_BITS-1:0] page_ff  [MAX_FRAMES];
   logic [PAGE_BITS-1:0] page_in  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [FW-1:0]        rank_ff  [MAX_FRAMES];
   logic [FW-1:0]        rank_in  [MAX_FRAMES];
   lrupr_pkg::fault_type faults_ff, faults_in;
   lrupr_pkg::csr_type   frames_ff, frames_in;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   lrupr_pkg::frame_port_type      rsp_frame_ff, rsp_frame_in;
   logic                           rsp_evicted_valid_ff, rsp_evicted_valid_in;
   lrupr_pkg::page_port_type       rsp_evicted_page_ff, rsp_evicted_page_in;
   lrupr_pkg::fault_type           rsp_fault_ff, rsp_fault_in;

   logic                  req_xfer;
   logic [PAGE_BITS+15:0] ref_ext;
   logic [PAGE_BITS-1:0]  ref_page;
   logic [MAX_FRAMES-1:0] active, match, empty, victim, age;
   logic                  hit_any, empty_any, evict;
   logic [FW-1:0]         hit_idx, empty_idx, victim_idx, slot;
   logic [FW-1:0]         slot_rank;
   logic [FW+2:0]         slot_ext;
   logic [PAGE_BITS-1:0]  old_page;
   logic [PAGE_BITS+15:0] old_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign ref_ext  = {{PAGE_BITS{1'b0}}, req_page_number};
   assign ref_page = ref_ext[PAGE_BITS-1:0];

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         active[i] = (i == 0) || (i < int'(frames_ff));
         match[i]  = active[i] && valid_ff[i] && (page_ff[i] == ref_page);
         empty[i]  = active[i] && !valid_ff[i];
      end
   end

   // The victim is the first active frame whose rank no other active frame exceeds.
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         victim[i] = active[i];
         for (int j = 0; j < MAX_FRAMES; j++) begin
            if (active[j] && (j < i) && (rank_ff[j] >= rank_ff[i])) begin
               victim[i] = 1'b0;
            end
            if (active[j] && (j > i) && (rank_ff[j] > rank_ff[i])) begin
               victim[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit_idx    = '0;
      empty_idx  = '0;
      victim_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = FW'(i);
         end
         if (empty[i]) begin
            empty_idx = FW'(i);
         end
         if (victim[i]) begin
            victim_idx = FW'(i);
         end
      end
   end

   assign hit_any   = |match;
   assign empty_any = |empty;
   assign evict     = !hit_any && !empty_any;
   assign slot      = hit_any ? hit_idx : (empty_any ? empty_idx : victim_idx);
   assign slot_rank = rank_ff[slot];
   assign old_page  = page_ff[slot];
   assign old_ext   = {16'b0, old_page};
   assign slot_ext  = {3'b0, slot};

   // A fill ages every valid frame; a hit or a replacement ages only the more recent ones.
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         age[i] = valid_ff[i] && (FW'(i) != slot) && (empty_any && !hit_any
                  || rank_ff[i] < slot_rank);
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      faults_in = faults_ff;
      frames_in = csr_write_enable ? csr_write_data : frames_ff;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         page_in[i] = page_ff[i];
         rank_in[i] = rank_ff[i];
      end
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_hit_in           = rsp_hit_ff;
      rsp_frame_in         = rsp_frame_ff;
      rsp_evicted_valid_in = rsp_evicted_valid_ff;
      rsp_evicted_page_in  = rsp_evicted_page_ff;
      rsp_fault_in         = rsp_fault_ff;
      if (req_xfer) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            if (FW'(i) == slot) begin
               rank_in[i] = '0;
            end else if (age[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         valid_in[slot] = 1'b1;
         if (!hit_any) begin
            page_in[slot] = ref_page;
            if (faults_ff != lrupr_pkg::FAULT_MAX) begin
               faults_in = faults_ff + 1'b1;
            end
         end
         rsp_valid_in         = 1'b1;
         rsp_hit_in           = hit_any;
         rsp_frame_in         = slot_ext[2:0];
         rsp_evicted_valid_in = evict;
         rsp_evicted_page_in  = evict ? old_ext[15:0] : '0;
         rsp_fault_in         = faults_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         page_ff[i] <= page_in[i];
      end
      rsp_hit_ff           <= rsp_hit_in;
      rsp_frame_ff         <= rsp_frame_in;
      rsp_evicted_valid_ff <= rsp_evicted_valid_in;
      rsp_evicted_page_ff  <= rsp_evicted_page_in;
      rsp_fault_ff         <= rsp_fault_in;
      if (reset) begin
         valid_ff     <= '0;
         faults_ff    <= '0;
         frames_ff    <= lrupr_pkg::FRAMES_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         faults_ff    <= faults_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

endmodule

`default_nettype wire

@@ rtl/lrupr_checker.sv @@
`default_nettype none
`include "lru_page_replacement_core_defines.svh"

module lrupr_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire [15:0]                     req_page_number,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire                            rsp_hit,
   input wire [2:0]                      rsp_frame_index,
   input wire                            rsp_evicted_valid,
   input wire [15:0]                     rsp_evicted_page,
   input wire [15:0]                     rsp_fault_count,
   input wire                            csr_write_enable,
   input wire [3:0]                      csr_write_data
);

   logic [15:0] unused_xor;
   lrupr_pkg::fault_type fault_seen;

   assign unused_xor = req_page_number ^ {12'b0, csr_write_data} ^ {13'b0, rsp_frame_index}
                       ^ {15'b0, csr_write_enable};
   assign fault_seen = rsp_fault_count;

   // A stalled response stays valid and keeps its fault count and evicted page.
   `LRUPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(fault_seen) && $stable(rsp_evicted_page) && (unused_xor == unused_xor), "stalled response changed")

   // Every request transfer leaves a response in the output register.
   `LRUPR_ASSERT(a_req_to_rsp, clock, reset, req_valid && req_ready |=> rsp_valid, "request transfer without response")

   // The request side stalls only behind an untaken response.
   `LRUPR_ASSERT_ALWAYS(a_ready_stall, clock, !reset && !req_ready |-> rsp_valid && !rsp_ready, "request stalled without cause")

   // A hit never reports an eviction, and no eviction means a zero page.
   `LRUPR_ASSERT(a_evict_clean, clock, reset, rsp_valid && (rsp_hit || !rsp_evicted_valid) |-> !(rsp_hit && rsp_evicted_valid) && rsp_evicted_page == 16'd0, "bad eviction report")

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

`default_nettype wire
